// ===== rtl/fuzzy_gain_scheduled_pd_core_assert.svh =====
// Assertion macros shared by the fuzzy gain-scheduled PD core modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef FUZZY_GAIN_SCHEDULED_PD_CORE_ASSERT_SVH
`define FUZZY_GAIN_SCHEDULED_PD_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FGPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FGPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fgpd_pkg.sv =====
// Shared types, constants, rule table and membership function for the
// fuzzy gain-scheduled PD core. No dependencies.
package fgpd_pkg;

  localparam int UNI_EDGE = 24576;   // universe edge six in Q4.12
  localparam int ONE_Q12  = 4096;
  localparam int RECIP3   = 174763;  // ceil(2^19 / 3)

  localparam logic [2:0] REG_KP_BASE    = 3'd0;
  localparam logic [2:0] REG_KP_EXTRA   = 3'd1;
  localparam logic [2:0] REG_KD_BASE    = 3'd2;
  localparam logic [2:0] REG_KD_EXTRA   = 3'd3;
  localparam logic [2:0] REG_ERROR_SPAN = 3'd4;
  localparam logic [2:0] REG_DELTA_SPAN = 3'd5;
  localparam logic [2:0] REG_OUT_HIGH   = 3'd6;
  localparam logic [2:0] REG_OUT_LOW    = 3'd7;

  typedef struct packed {
    logic [15:0]        kp_base;
    logic [15:0]        kp_extra;
    logic [15:0]        kd_base;
    logic [15:0]        kd_extra;
    logic [14:0]        error_span;
    logic [14:0]        delta_span;
    logic signed [15:0] out_high;
    logic signed [15:0] out_low;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  idx;  // lower rule index; upper one is idx + 1
    logic [12:0] up;   // weight on idx + 1
    logic [12:0] lo;   // weight on idx
  } memb_t;

  localparam logic signed [3:0] RULE_TAB [0:6][0:6] = '{
    '{ 4'sd6,  4'sd6,  4'sd4,  4'sd6,  4'sd4,  4'sd0,  4'sd0},
    '{ 4'sd6,  4'sd6,  4'sd4,  4'sd4,  4'sd2,  4'sd0, -4'sd2},
    '{ 4'sd4,  4'sd4,  4'sd2,  4'sd2,  4'sd0, -4'sd2, -4'sd2},
    '{ 4'sd4,  4'sd4,  4'sd2,  4'sd0, -4'sd2, -4'sd4, -4'sd4},
    '{ 4'sd2,  4'sd2,  4'sd0, -4'sd2, -4'sd2, -4'sd4, -4'sd4},
    '{ 4'sd2,  4'sd0, -4'sd2, -4'sd4, -4'sd4, -4'sd6, -4'sd6},
    '{ 4'sd0,  4'sd0, -4'sd4, -4'sd6, -4'sd4, -4'sd6, -4'sd6}
  };

  // Triangular memberships of a clamped Q4.12 value.
  function automatic memb_t member(input logic signed [15:0] q);
    logic signed [16:0] us;
    logic [15:0]        u;
    logic [2:0]         s;
    logic [13:0]        f;
    memb_t              m;
    us = $signed({q[15], q}) + 17'sd24576;
    u  = us[15:0];
    s  = u[15:13];
    if (s == 3'd6) begin
      // right edge of the universe folds into the last segment
      s = 3'd5;
      f = 14'd8192;
    end else begin
      f = {1'b0, u[12:0]};
    end
    m.idx = s;
    m.up  = f[13:1];
    m.lo  = 13'(ONE_Q12) - f[13:1];
    return m;
  endfunction

endpackage

// ===== rtl/fgpd_in_if.sv =====
// Input channel of the fuzzy PD core: valid/ready with setpoint and measured.
// Depends on nothing.
interface fgpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] setpoint;
  logic signed [15:0] measured;
  modport source (output valid, setpoint, measured, input ready);
  modport sink (input valid, setpoint, measured, output ready);
endinterface

// ===== rtl/fgpd_out_if.sv =====
// Result channel of the fuzzy PD core: valid/ready with the drive value.
// Depends on nothing.
interface fgpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

// ===== rtl/fgpd_regs.sv =====
// APB-style configuration register bank of the fuzzy PD core.
// Depends on fgpd_pkg.
module fgpd_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output fgpd_pkg::cfg_t cfg
);

  fgpd_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_base    <= 16'd4403;
      cfg_r.kp_extra   <= 16'd8192;
      cfg_r.kd_base    <= 16'd154;
      cfg_r.kd_extra   <= 16'd0;
      cfg_r.error_span <= 15'd160;
      cfg_r.delta_span <= 15'd10;
      cfg_r.out_high   <= 16'sd600;
      cfg_r.out_low    <= -16'sd600;
    end else if (wr_en) begin
      case (paddr[4:2])
        fgpd_pkg::REG_KP_BASE:    cfg_r.kp_base    <= pwdata[15:0];
        fgpd_pkg::REG_KP_EXTRA:   cfg_r.kp_extra   <= pwdata[15:0];
        fgpd_pkg::REG_KD_BASE:    cfg_r.kd_base    <= pwdata[15:0];
        fgpd_pkg::REG_KD_EXTRA:   cfg_r.kd_extra   <= pwdata[15:0];
        fgpd_pkg::REG_ERROR_SPAN: cfg_r.error_span <= pwdata[14:0];
        fgpd_pkg::REG_DELTA_SPAN: cfg_r.delta_span <= pwdata[14:0];
        fgpd_pkg::REG_OUT_HIGH:   cfg_r.out_high   <= $signed(pwdata[15:0]);
        fgpd_pkg::REG_OUT_LOW:    cfg_r.out_low    <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      fgpd_pkg::REG_KP_BASE:    prdata = {16'd0, cfg_r.kp_base};
      fgpd_pkg::REG_KP_EXTRA:   prdata = {16'd0, cfg_r.kp_extra};
      fgpd_pkg::REG_KD_BASE:    prdata = {16'd0, cfg_r.kd_base};
      fgpd_pkg::REG_KD_EXTRA:   prdata = {16'd0, cfg_r.kd_extra};
      fgpd_pkg::REG_ERROR_SPAN: prdata = {17'd0, cfg_r.error_span};
      fgpd_pkg::REG_DELTA_SPAN: prdata = {17'd0, cfg_r.delta_span};
      fgpd_pkg::REG_OUT_HIGH:   prdata = {16'd0, cfg_r.out_high};
      fgpd_pkg::REG_OUT_LOW:    prdata = {16'd0, cfg_r.out_low};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/fgpd_qdiv.sv =====
// Bit-serial quantiser: floor(mag * 24576 / span), clamped to 24576.
// One quotient bit per cycle. Depends on fgpd_pkg and the macro header.
`include "fuzzy_gain_scheduled_pd_core_assert.svh"

module fgpd_qdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] mag,
  input  logic [14:0] span,
  output logic        done,
  output logic [14:0] q_mag
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r;
  logic [14:0] rem_r;
  logic [15:0] quot_r;
  logic        ovf_r;
  logic [14:0] span_r;
  logic [15:0] trial;
  logic        ge;
  logic [18:0] mag3;

  assign mag3  = {2'b00, mag} + {1'b0, mag, 1'b0};
  assign trial = {rem_r, dvd_r[31]};
  assign ge    = trial >= {1'b0, span_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= {mag3, 13'd0};
      rem_r  <= 15'd0;
      quot_r <= 16'd0;
      ovf_r  <= 1'b0;
      // a zero span acts as one
      span_r <= (span == 15'd0) ? 15'd1 : span;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[30:0], 1'b0};
      rem_r  <= ge ? 15'(trial - {1'b0, span_r}) : trial[14:0];
      quot_r <= {quot_r[14:0], ge};
      ovf_r  <= ovf_r | quot_r[15];
    end
  end

  assign done  = done_r;
  assign q_mag = (ovf_r || quot_r > 16'(fgpd_pkg::UNI_EDGE)) ?
                 15'(fgpd_pkg::UNI_EDGE) : quot_r[14:0];

  `FGPD_ASSERT_IMP(a_qdiv_clamp, done_r, q_mag <= 15'(fgpd_pkg::UNI_EDGE), "quantiser beyond edge")
  `FGPD_ASSERT_NXT(a_qdiv_start, start, busy_r && cnt_r == 5'd0, "quantiser failed to start")
  `FGPD_ASSERT_IMP(a_qdiv_rem, busy_r, rem_r < span_r, "remainder not below divisor")

endmodule

// ===== rtl/fuzzy_gain_scheduled_pd_core.sv =====
// Fuzzy gain-scheduled PD core. An item passes from acceptance to its result
// through the two bit-serial quantisers, which run side by side, then the
// membership, rule-sum and gain states, the bit-serial PD multiply-accumulate
// and the truncate and clamp states. A new item is accepted once the previous
// one has reached the output register, so an item is not taken before the last
// one is through, and a finished result may wait there while the next item is
// worked on. Write the configuration registers only while the core is idle.
// Depends on fgpd_pkg, fgpd_in_if, fgpd_out_if, fgpd_regs and fgpd_qdiv.
`include "fuzzy_gain_scheduled_pd_core_assert.svh"

module fuzzy_gain_scheduled_pd_core (
  input  logic        clk,
  input  logic        rst_n,
  fgpd_in_if.sink     in_if,
  fgpd_out_if.source  out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MEMB  = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_GAIN  = 3'd4;
  localparam logic [2:0] ST_MAC   = 3'd5;
  localparam logic [2:0] ST_TRUNC = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  fgpd_pkg::cfg_t cfg;

  logic [2:0]          state_r, state_nxt;
  logic [4:0]          step_r, step_nxt;
  logic                out_v_r, out_v_nxt;
  logic signed [16:0]  prev_r;
  logic signed [15:0]  out_d_r;

  logic signed [16:0]  e_r;
  logic signed [17:0]  de_r;
  fgpd_pkg::memb_t     me_r, mc_r;
  logic [25:0]         prod_r;
  logic signed [3:0]   rule_r;
  logic signed [27:0]  acc_r;
  logic [42:0]         p43_r;
  logic [35:0]         q3_r;
  logic [16:0]         kp_g_r, kd_g_r;
  logic signed [36:0]  v_r, esh_r, desh_r;
  logic signed [26:0]  d_r;

  logic                in_acc, load;
  logic signed [16:0]  e_in;
  logic signed [17:0]  de_in;
  logic [16:0]         mag_e, mag_d;
  logic                qe_done, qd_done;
  logic [14:0]         qe_mag, qd_mag;
  logic signed [15:0]  qe, qd;
  logic                sel_a, sel_b;
  logic [12:0]         m_a, m_b;
  logic [2:0]          row, col;
  logic signed [27:0]  term;
  logic [26:0]         mag;
  logic [17:0]         t2;
  logic signed [36:0]  vn;
  logic signed [26:0]  hi27, lo27, dcl;

  fgpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_acc = in_if.valid & in_if.ready;
  assign e_in   = 17'(in_if.setpoint) - 17'(in_if.measured);
  assign de_in  = 18'(e_in) - 18'(prev_r);
  assign mag_e  = e_in[16] ? 17'(-e_in) : e_in;
  assign mag_d  = de_in[17] ? 17'(-de_in) : de_in[16:0];

  fgpd_qdiv u_qdiv_e (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .mag   (mag_e),
    .span  (cfg.error_span),
    .done  (qe_done),
    .q_mag (qe_mag)
  );

  fgpd_qdiv u_qdiv_d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .mag   (mag_d),
    .span  (cfg.delta_span),
    .done  (qd_done),
    .q_mag (qd_mag)
  );

  // restore the sign of each quantised value
  assign qe = e_r[16] ? -$signed({1'b0, qe_mag}) : $signed({1'b0, qe_mag});
  assign qd = de_r[17] ? -$signed({1'b0, qd_mag}) : $signed({1'b0, qd_mag});

  // rule sum: one membership product per cycle, weighted by its rule in the following cycle
  assign sel_a = step_r[1];
  assign sel_b = step_r[0];
  assign m_a   = sel_a ? me_r.up : me_r.lo;
  assign m_b   = sel_b ? mc_r.up : mc_r.lo;
  assign row   = me_r.idx + {2'b00, sel_a};
  assign col   = mc_r.idx + {2'b00, sel_b};
  assign term  = $signed({2'b00, prod_r}) * 28'(rule_r);

  assign mag = acc_r[27] ? 27'(-acc_r) : acc_r[26:0];
  assign t2  = p43_r[42:25];

  assign vn   = v_r[36] ? v_r + 37'sd1023 : v_r;
  assign hi27 = 27'($signed(cfg.out_high));
  assign lo27 = 27'($signed(cfg.out_low));
  always_comb begin
    // with inverted limits, the upper limit wins only for values above it
    if (d_r > hi27) begin
      dcl = hi27;
    end else if (d_r < lo27) begin
      dcl = lo27;
    end else begin
      dcl = d_r;
    end
  end

  assign load = (state_r == ST_DONE) && (!out_v_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (qe_done && qd_done) state_nxt = ST_MEMB;
      end
      ST_MEMB: begin
        state_nxt = ST_SUM;
        step_nxt  = 5'd0;
      end
      ST_SUM: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd4) begin
          state_nxt = ST_GAIN;
          step_nxt  = 5'd0;
        end
      end
      ST_GAIN: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd3) begin
          state_nxt = ST_MAC;
          step_nxt  = 5'd0;
        end
      end
      ST_MAC: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd16) begin
          state_nxt = ST_TRUNC;
          step_nxt  = 5'd0;
        end
      end
      ST_TRUNC: state_nxt = ST_DONE;
      ST_DONE: begin
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_v_nxt = (out_v_r & ~out_if.ready) | load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 5'd0;
      out_v_r <= 1'b0;
      prev_r  <= 17'sd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      out_v_r <= out_v_nxt;
      if (in_acc) prev_r <= e_in;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          e_r  <= e_in;
          de_r <= de_in;
        end
      end
      ST_MEMB: begin
        me_r <= fgpd_pkg::member(qe);
        mc_r <= fgpd_pkg::member(qd);
      end
      ST_SUM: begin
        prod_r <= 26'(m_a) * 26'(m_b);
        rule_r <= fgpd_pkg::RULE_TAB[row][col];
        acc_r  <= (step_r == 5'd0) ? 28'sd0 : acc_r + term;
      end
      ST_GAIN: begin
        case (step_r[1:0])
          2'd0: p43_r <= 43'(cfg.kp_extra) * 43'(mag);
          2'd1: begin
            q3_r  <= 36'(t2) * 36'(fgpd_pkg::RECIP3);
            p43_r <= 43'(cfg.kd_extra) * 43'(mag);
          end
          2'd2: begin
            kp_g_r <= {1'b0, cfg.kp_base} + q3_r[35:19];
            q3_r   <= 36'(t2) * 36'(fgpd_pkg::RECIP3);
          end
          default: begin
            kd_g_r <= {1'b0, cfg.kd_base} + q3_r[35:19];
            esh_r  <= 37'(e_r);
            desh_r <= 37'(de_r);
            v_r    <= 37'sd0;
          end
        endcase
      end
      ST_MAC: begin
        // one gain bit per cycle, LSB first
        v_r    <= v_r + (kp_g_r[0] ? esh_r : 37'sd0) + (kd_g_r[0] ? desh_r : 37'sd0);
        kp_g_r <= {1'b0, kp_g_r[16:1]};
        kd_g_r <= {1'b0, kd_g_r[16:1]};
        esh_r  <= esh_r <<< 1;
        desh_r <= desh_r <<< 1;
      end
      ST_TRUNC: d_r <= vn[36:10];
      ST_DONE: begin
        if (load) out_d_r <= dcl[15:0];
      end
      default: ;
    endcase
  end

  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = out_v_r;
  assign out_if.drive = out_d_r;

  `FGPD_ASSERT_NXT(a_acc_to_div, in_acc, state_r == ST_DIV, "accepted item did not start")
  `FGPD_ASSERT_IMP(a_memb_unity, state_r == ST_SUM, (me_r.up + me_r.lo == 13'd4096) && (mc_r.up + mc_r.lo == 13'd4096), "memberships do not sum to one")
  `FGPD_ASSERT_IMP(a_sum_bound, state_r == ST_GAIN, mag <= 27'd100663296, "rule sum beyond six")

endmodule
